// File: hdl/acpb_pkg.sv
// Package for the antialiased circle pixel blend unit: sizes, types, register map, helpers.
`timescale 1ns / 1ps

package acpb_pkg;

    localparam int AA_RES     = 2;
    localparam int COORD_BITS = 11;

    localparam int PIX_W    = 11;
    localparam int CENTER_W = 12;
    localparam int RADIUS_W = 11;
    localparam int COLOR_W  = 32;
    localparam int COV_W    = 3;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;

    localparam int G         = AA_RES + 1;
    localparam int TWO_G     = 2 * G;
    localparam int AA2       = AA_RES * AA_RES;
    localparam int DIFF_W    = COORD_BITS + 2;
    localparam int DX_W      = DIFF_W + $clog2(TWO_G) + 1;
    localparam int SQ_W      = 2 * DX_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int RSQ_W     = 2 * COORD_BITS;
    localparam int LIM_SCALE = 4 * G * G;
    localparam int CNT_W     = $clog2(AA2 + 1);
    localparam int AV_W      = CH_W + CNT_W;
    localparam int RECIP_K   = AV_W + $clog2(AA2);
    localparam int MIX_W     = 2 * CH_W + 1;
    localparam int COV_MAX   = (1 << COV_W) - 1;

    localparam int IN_W        = 2 * PIX_W + COLOR_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = COLOR_W + COV_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int REG_N     = 4;
    localparam int REG_IDX_W = $clog2(REG_N);
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic signed [COORD_BITS:0]   t_ccoord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [DX_W-1:0]       t_dx;
    typedef logic signed [SQ_W-1:0]       t_sq;
    typedef logic [SUM_W-1:0]             t_sum;
    typedef logic [RSQ_W-1:0]             t_rsq;
    typedef logic [AA2-1:0]               t_hits;
    typedef logic [CNT_W-1:0]             t_cnt;
    typedef logic [CNT_W+COV_W-1:0]       t_cntx;
    typedef logic [COV_W-1:0]             t_cov;
    typedef logic [CH_W-1:0]              t_ch;
    typedef logic [COLOR_W-1:0]           t_color;
    typedef logic [AV_W-1:0]              t_av;
    typedef logic [RECIP_K:0]             t_recip;
    typedef logic [AV_W+RECIP_K:0]        t_aprod;
    typedef logic [MIX_W-1:0]             t_mix;

    localparam t_recip RECIP_M = t_recip'(((64'd1 << RECIP_K) + AA2 - 1) / AA2);
    localparam t_ch    CH_MAX  = '1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CENTER_X = 0,
        REG_CENTER_Y = 1,
        REG_RADIUS   = 2,
        REG_FILL     = 3
    } t_reg_idx;

    typedef struct packed {
        t_ccoord center_x;
        t_ccoord center_y;
        t_sum    limit;
        t_color  fill;
    } t_cfg;

    typedef struct packed {
        t_hits  hits;
        t_color dest;
    } t_cov_beat;

    function automatic t_cov sat_cov(input t_cnt c);
        t_cntx cx;
        cx = t_cntx'(c);
        if (cx > t_cntx'(COV_MAX)) begin
            return t_cov'(COV_MAX);
        end
        return t_cov'(cx);
    endfunction

endpackage

// File: hdl/acpb_cfg.sv
// Configuration register file with APB-style access and derived radius limit.
`timescale 1ns / 1ps

module acpb_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [acpb_pkg::PADDR_W-1:0]   paddr,
    input  logic [acpb_pkg::PDATA_W-1:0]   pwdata,
    output logic [acpb_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output acpb_pkg::t_cfg                 o_cfg
);

    logic [acpb_pkg::CENTER_W-1:0] r_center_x;
    logic [acpb_pkg::CENTER_W-1:0] r_center_y;
    logic [acpb_pkg::RADIUS_W-1:0] r_radius;
    acpb_pkg::t_color              r_fill;
    acpb_pkg::t_rsq                r_rsq;
    acpb_pkg::t_sum                r_limit;
    acpb_pkg::t_reg_idx            reg_idx;
    acpb_pkg::t_coord              rad_c;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = acpb_pkg::t_reg_idx'(paddr[acpb_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign rad_c   = acpb_pkg::t_coord'(r_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
            r_fill     <= '0;
            r_rsq      <= '0;
            r_limit    <= '0;
        end else begin
            r_rsq   <= acpb_pkg::t_rsq'(rad_c) * acpb_pkg::t_rsq'(rad_c);
            r_limit <= acpb_pkg::t_sum'(r_rsq) * acpb_pkg::t_sum'(acpb_pkg::LIM_SCALE);
            if (wr_en) begin
                case (reg_idx)
                    acpb_pkg::REG_CENTER_X: begin
                        r_center_x <= pwdata[acpb_pkg::CENTER_W-1:0];
                    end
                    acpb_pkg::REG_CENTER_Y: begin
                        r_center_y <= pwdata[acpb_pkg::CENTER_W-1:0];
                    end
                    acpb_pkg::REG_RADIUS: begin
                        r_radius <= pwdata[acpb_pkg::RADIUS_W-1:0];
                    end
                    acpb_pkg::REG_FILL: begin
                        r_fill <= pwdata[acpb_pkg::COLOR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (reg_idx)
            acpb_pkg::REG_CENTER_X: prdata = acpb_pkg::PDATA_W'(r_center_x);
            acpb_pkg::REG_CENTER_Y: prdata = acpb_pkg::PDATA_W'(r_center_y);
            acpb_pkg::REG_RADIUS:   prdata = acpb_pkg::PDATA_W'(r_radius);
            acpb_pkg::REG_FILL:     prdata = acpb_pkg::PDATA_W'(r_fill);
            default:                prdata = '0;
        endcase
    end

    // centre is reinterpreted as a (COORD_BITS+1)-bit two's complement value
    assign o_cfg.center_x = acpb_pkg::t_ccoord'(r_center_x);
    assign o_cfg.center_y = acpb_pkg::t_ccoord'(r_center_y);
    assign o_cfg.limit    = r_limit;
    assign o_cfg.fill     = r_fill;

endmodule

// File: hdl/acpb_coverage.sv
// Subsample coverage pipeline: offsets, squares, distance compare against the radius limit.
`timescale 1ns / 1ps

module acpb_coverage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acpb_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [acpb_pkg::PIX_W-1:0]    i_pixel_x,
    input  logic [acpb_pkg::PIX_W-1:0]    i_pixel_y,
    input  acpb_pkg::t_color              i_dest,
    output logic                          o_valid,
    input  logic                          i_ready,
    output acpb_pkg::t_cov_beat           o_beat
);

    localparam int NSTG = 3;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   stage_en;
    acpb_pkg::t_color  r_dest [NSTG];
    acpb_pkg::t_dx     r_dx [acpb_pkg::AA_RES];
    acpb_pkg::t_dx     r_dy [acpb_pkg::AA_RES];
    acpb_pkg::t_sq     r_sqx [acpb_pkg::AA_RES];
    acpb_pkg::t_sq     r_sqy [acpb_pkg::AA_RES];
    acpb_pkg::t_hits   r_hits;
    acpb_pkg::t_hits   n_hits;
    acpb_pkg::t_diff   diff_x;
    acpb_pkg::t_diff   diff_y;

    always_comb begin
        stage_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_ready = stage_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (stage_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) r_dest[0] <= i_dest;
        for (int k = 1; k < NSTG; k++) begin
            if (stage_en[k]) r_dest[k] <= r_dest[k-1];
        end
    end

    // stage 1: pixel minus centre, scaled to the subsample grid
    assign diff_x = acpb_pkg::t_diff'(acpb_pkg::t_coord'(i_pixel_x))
                  - acpb_pkg::t_diff'(i_cfg.center_x);
    assign diff_y = acpb_pkg::t_diff'(acpb_pkg::t_coord'(i_pixel_y))
                  - acpb_pkg::t_diff'(i_cfg.center_y);

    for (genvar s = 0; s < acpb_pkg::AA_RES; s++) begin : g_lane
        localparam int OFF = 2 + 2 * s - acpb_pkg::G;

        always_ff @(posedge i_clk) begin
            if (stage_en[0]) begin
                r_dx[s] <= acpb_pkg::t_dx'(diff_x) * acpb_pkg::t_dx'(acpb_pkg::TWO_G)
                         + acpb_pkg::t_dx'(OFF);
                r_dy[s] <= acpb_pkg::t_dx'(diff_y) * acpb_pkg::t_dx'(acpb_pkg::TWO_G)
                         + acpb_pkg::t_dx'(OFF);
            end
            if (stage_en[1]) begin
                r_sqx[s] <= acpb_pkg::t_sq'(r_dx[s]) * acpb_pkg::t_sq'(r_dx[s]);
                r_sqy[s] <= acpb_pkg::t_sq'(r_dy[s]) * acpb_pkg::t_sq'(r_dy[s]);
            end
        end
    end

    // stage 3: one compare per subsample
    always_comb begin
        for (int sx = 0; sx < acpb_pkg::AA_RES; sx++) begin
            for (int sy = 0; sy < acpb_pkg::AA_RES; sy++) begin
                n_hits[sx*acpb_pkg::AA_RES+sy] =
                    (acpb_pkg::t_sum'($unsigned(r_sqx[sx]))
                     + acpb_pkg::t_sum'($unsigned(r_sqy[sy]))) <= i_cfg.limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) r_hits <= n_hits;
    end

    assign o_valid     = r_vld[NSTG-1];
    assign o_beat.hits = r_hits;
    assign o_beat.dest = r_dest[NSTG-1];

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> ((&r_vld) && !i_ready))
        else $error("coverage pipe stalled with a bubble inside");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && (i_cfg.limit == '0)) |-> (r_hits == '0))
        else $error("hit reported with zero radius");

endmodule

// File: hdl/acpb_blend.sv
// Blend pipeline: hit count, alpha scaling, channel mix, divide by 255, output register.
`timescale 1ns / 1ps

module acpb_blend (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  acpb_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  acpb_pkg::t_cov_beat   i_beat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output acpb_pkg::t_color      o_color,
    output acpb_pkg::t_cov        o_coverage
);

    localparam int NSTG = 4;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   stage_en;
    acpb_pkg::t_color  r_dest [NSTG];
    acpb_pkg::t_cnt    r_cnt [NSTG-1];
    acpb_pkg::t_av     r_v;
    acpb_pkg::t_ch     r_a;
    acpb_pkg::t_mix    r_mix [acpb_pkg::NUM_CH];
    acpb_pkg::t_ch     r_out_ch [acpb_pkg::NUM_CH];
    acpb_pkg::t_cov    r_cov;
    acpb_pkg::t_cnt    hit_cnt;
    acpb_pkg::t_aprod  a_prod;
    acpb_pkg::t_av     a_full;
    acpb_pkg::t_ch     inv_a;
    acpb_pkg::t_ch     src_alpha;

    always_comb begin
        stage_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_ready = stage_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (stage_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign hit_cnt   = acpb_pkg::t_cnt'($countones(i_beat.hits));
    assign src_alpha = i_cfg.fill[acpb_pkg::COLOR_W-1 -: acpb_pkg::CH_W];
    assign a_prod    = acpb_pkg::t_aprod'(r_v) * acpb_pkg::t_aprod'(acpb_pkg::RECIP_M);
    assign a_full    = acpb_pkg::t_av'(a_prod >> acpb_pkg::RECIP_K);
    assign inv_a     = acpb_pkg::CH_MAX - r_a;

    always_ff @(posedge i_clk) begin
        // stage 1: count hits, alpha times count
        if (stage_en[0]) begin
            r_dest[0] <= i_beat.dest;
            r_cnt[0]  <= hit_cnt;
            r_v       <= acpb_pkg::t_av'(src_alpha) * acpb_pkg::t_av'(hit_cnt);
        end
        // stage 2: divide by the subsample count via reciprocal
        if (stage_en[1]) begin
            r_dest[1] <= r_dest[0];
            r_cnt[1]  <= r_cnt[0];
            r_a       <= (a_full > acpb_pkg::t_av'(acpb_pkg::CH_MAX)) ? acpb_pkg::CH_MAX
                                                                      : acpb_pkg::t_ch'(a_full);
        end
        // stage 3: weighted channel sums
        if (stage_en[2]) begin
            r_dest[2] <= r_dest[1];
            r_cnt[2]  <= r_cnt[1];
            for (int c = 0; c < acpb_pkg::NUM_CH; c++) begin
                r_mix[c] <= acpb_pkg::t_mix'(r_dest[1][c*acpb_pkg::CH_W +: acpb_pkg::CH_W])
                              * acpb_pkg::t_mix'(inv_a)
                          + acpb_pkg::t_mix'(i_cfg.fill[c*acpb_pkg::CH_W +: acpb_pkg::CH_W])
                              * acpb_pkg::t_mix'(r_a);
            end
        end
    end

    // stage 4: x/255 as (x + 1 + (x >> 8)) >> 8, exact for x below 65535
    for (genvar c = 0; c < acpb_pkg::NUM_CH; c++) begin : g_div
        acpb_pkg::t_mix q_sum;
        assign q_sum = r_mix[c] + acpb_pkg::t_mix'(1) + (r_mix[c] >> acpb_pkg::CH_W);

        always_ff @(posedge i_clk) begin
            if (stage_en[3]) begin
                r_out_ch[c] <= (q_sum[acpb_pkg::MIX_W-1:acpb_pkg::CH_W] >
                                (acpb_pkg::MIX_W - acpb_pkg::CH_W)'(acpb_pkg::CH_MAX))
                               ? acpb_pkg::CH_MAX
                               : q_sum[acpb_pkg::CH_W +: acpb_pkg::CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_dest[3] <= r_dest[2];
            r_cov     <= acpb_pkg::sat_cov(r_cnt[2]);
        end
    end

    always_comb begin
        o_color = r_dest[3];
        for (int c = 0; c < acpb_pkg::NUM_CH; c++) begin
            o_color[c*acpb_pkg::CH_W +: acpb_pkg::CH_W] = r_out_ch[c];
        end
    end

    assign o_valid    = r_vld[NSTG-1];
    assign o_coverage = r_cov;

    a_zero_cov_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && (r_cov == '0)) |-> (o_color == r_dest[NSTG-1]))
        else $error("uncovered pixel changed its color");

    a_zero_cnt_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && (r_cnt[1] == '0)) |-> (r_a == '0))
        else $error("nonzero alpha with zero coverage");

endmodule

// File: hdl/antialiased_circle_pixel_blend_unit.sv
// Top level of the antialiased circle pixel blend unit.
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: pixel_x[10:0], pixel_y[21:11], dest_color[53:22], zero pad to 56
// m_axis  | out | tdata: blended_color[31:0], coverage[34:32], zero pad to 40
// apb     | cfg | 0x0 center_x, 0x4 center_y, 0x8 radius, 0xC fill_color
// One beat per clock sustained while m_axis_tready stays high; a beat passes through
// 3 coverage stages and 4 blend stages, including the output register.
// Reset clears valid bits and config registers; no clearing pass is needed.
// Each stage holds on a stall and fills bubbles, so input keeps flowing while
// a result waits at the output, until all seven stages hold a beat.
`timescale 1ns / 1ps

module antialiased_circle_pixel_blend_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pixel_x, pixel_y, dest_color
    input  logic [acpb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // blended_color, coverage
    output logic [acpb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [acpb_pkg::PADDR_W-1:0]         paddr,
    input  logic [acpb_pkg::PDATA_W-1:0]         pwdata,
    output logic [acpb_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    acpb_pkg::t_cfg       cfg;
    acpb_pkg::t_cov_beat  cov_beat;
    logic                 cov_valid;
    logic                 cov_ready;
    acpb_pkg::t_color     out_color;
    acpb_pkg::t_cov       out_cov;

    acpb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    acpb_coverage u_coverage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pixel_x (s_axis_tdata[acpb_pkg::PIX_W-1:0]),
        .i_pixel_y (s_axis_tdata[acpb_pkg::PIX_W +: acpb_pkg::PIX_W]),
        .i_dest    (s_axis_tdata[2*acpb_pkg::PIX_W +: acpb_pkg::COLOR_W]),
        .o_valid   (cov_valid),
        .i_ready   (cov_ready),
        .o_beat    (cov_beat)
    );

    acpb_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (cov_valid),
        .o_ready    (cov_ready),
        .i_beat     (cov_beat),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_color    (out_color),
        .o_coverage (out_cov)
    );

    assign m_axis_tdata = acpb_pkg::OUT_TDATA_W'({out_cov, out_color});

endmodule

// File: tb/sv/antialiased_circle_pixel_blend_unit_test.sv
// Self-checking bench for the circle coverage pixel blend unit: directed rows, random pixels.
`timescale 1ns / 1ps

module antialiased_circle_pixel_blend_unit_test;
    import acpb_pkg::*;

    localparam int PIPE_LATENCY = 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int CIRCLES      = 5;
    localparam int PIXELS_EACH  = 57;

    typedef struct packed {
        t_color blended;
        t_cov   cov;
    } shade_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e kind;
        t_reg_idx  reg_sel;
        logic [PDATA_W-1:0] value;
        t_coord    px;
        t_coord    py;
        t_color    dest;
        logic      known;
        shade_t    known_shade;
    } row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // pixel_x[10:0], pixel_y[21:11], dest_color[53:22], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // blended_color[31:0], coverage[34:32], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // circle setup as the block should hold it
    t_ccoord         circ_cx = '0;
    t_ccoord         circ_cy = '0;
    logic [RADIUS_W-1:0] circ_r = '0;
    t_color          circ_fill = '0;

    shade_t pending_pixels[$];
    row_t   directed_rows[$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int errors = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int circles_set = 0;
    int cov_seen[5] = '{default: 0};

    shade_t got_shade;
    shade_t want_shade;

    antialiased_circle_pixel_blend_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_ch blend_channel(input t_ch d, input t_ch s, input int a);
        int v;
        v = (int'(d) * (255 - a) + int'(s) * a) / 255;
        if (v > 255) begin
            v = 255;
        end
        return t_ch'(v);
    endfunction

    function automatic shade_t shade_pixel(input t_coord px, input t_coord py, input t_color dest);
        longint g;
        longint lim;
        longint dx;
        longint dy;
        int     hits;
        int     a;
        shade_t res;
        g = longint'(AA_RES) + 1;
        lim = 4 * g * g * longint'(circ_r) * longint'(circ_r);
        hits = 0;
        for (int sx = 0; sx < AA_RES; sx++) begin
            for (int sy = 0; sy < AA_RES; sy++) begin
                dx = 2 * g * longint'(px) + 2 + 2 * sx - 2 * g * longint'(circ_cx) - g;
                dy = 2 * g * longint'(py) + 2 + 2 * sy - 2 * g * longint'(circ_cy) - g;
                if (dx * dx + dy * dy <= lim) begin
                    hits++;
                end
            end
        end
        a = int'(circ_fill[31:24]) * hits / (AA_RES * AA_RES);
        if (a > 255) begin
            a = 255;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            res.blended[CH_W*ch +: CH_W] =
                blend_channel(dest[CH_W*ch +: CH_W], circ_fill[CH_W*ch +: CH_W], a);
        end
        res.blended[31:24] = dest[31:24];
        res.cov = (hits > 7) ? t_cov'(7) : t_cov'(hits);
        return res;
    endfunction

    function automatic void row_write(input t_reg_idx sel, input logic [PDATA_W-1:0] value);
        row_t row;
        row = '{kind: ROW_WRITE, reg_sel: sel, value: value, px: '0, py: '0, dest: '0,
                known: 1'b0, known_shade: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void row_known(input t_coord px, input t_coord py, input t_color dest,
                                      input logic is_known, input t_color color, input t_cov cov);
        row_t row;
        row = '{kind: ROW_PIXEL, reg_sel: REG_CENTER_X, value: '0, px: px, py: py, dest: dest,
                known: is_known, known_shade: '{color, cov}};
        directed_rows.push_back(row);
    endfunction

    function automatic void row_pixel(input t_coord px, input t_coord py, input t_color dest);
        row_known(px, py, dest, 1'b0, '0, '0);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // result side: random stalls, compare each beat against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got_shade = '{m_axis_tdata[COLOR_W-1:0], m_axis_tdata[COLOR_W +: COV_W]};
                pixels_checked++;
                if (got_shade.cov <= 4) begin
                    cov_seen[got_shade.cov]++;
                end
                if (pending_pixels.size() == 0) begin
                    flag_error($sformatf("unexpected beat color=%08h cov=%0d",
                                         got_shade.blended, got_shade.cov));
                end else begin
                    want_shade = pending_pixels.pop_front();
                    if (got_shade.blended !== want_shade.blended ||
                        got_shade.cov !== want_shade.cov) begin
                        flag_error($sformatf("mismatch color exp=%08h got=%08h cov exp=%0d got=%0d",
                                             want_shade.blended, got_shade.blended,
                                             want_shade.cov, got_shade.cov));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input t_coord px, input t_coord py, input t_color dest,
                              input shade_t expected);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) begin
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({dest, py, px});
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_pixels.push_back(expected);
        pixels_sent++;
    endtask

    // drop valid and let every outstanding pixel drain before touching registers
    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_CENTER_X: circ_cx = t_ccoord'(value[CENTER_W-1:0]);
            REG_CENTER_Y: circ_cy = t_ccoord'(value[CENTER_W-1:0]);
            REG_RADIUS:   circ_r = value[RADIUS_W-1:0];
            REG_FILL:     circ_fill = value[COLOR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_circle(input int mode, input int k);
        logic [PDATA_W-1:0] vx;
        logic [PDATA_W-1:0] vy;
        logic [PDATA_W-1:0] vr;
        logic [PDATA_W-1:0] vf;
        vx = $urandom();
        vy = $urandom();
        vr = $urandom();
        vf = $urandom();
        if ($urandom_range(3) != 0) begin
            vx[CENTER_W-1] = 1'b0;
            vy[CENTER_W-1] = 1'b0;
        end
        vr[RADIUS_W-1:0] = ($urandom_range(7) == 0) ? RADIUS_W'($urandom_range(2047))
                                                    : RADIUS_W'($urandom_range(48));
        if (k == 0) begin
            case (mode)
                0: begin
                    vx[CENTER_W-1:0] = 12'h800;
                    vy[CENTER_W-1:0] = 12'h7FF;
                    vr[RADIUS_W-1:0] = 11'h7FF;
                    vf = 32'hFFFF_FFFF;
                end
                1: begin
                    vx[CENTER_W-1:0] = 12'h7FF;
                    vy[CENTER_W-1:0] = 12'h800;
                    vr[RADIUS_W-1:0] = '0;
                    vf = 32'h0000_0000;
                end
                default: begin
                    vx[CENTER_W-1:0] = '0;
                    vy[CENTER_W-1:0] = '0;
                    vr[RADIUS_W-1:0] = 11'd1;
                    vf = 32'hFF00_0000;
                end
            endcase
        end
        settle_pipeline();
        write_reg(REG_CENTER_X, vx);
        write_reg(REG_CENTER_Y, vy);
        write_reg(REG_RADIUS, vr);
        write_reg(REG_FILL, vf);
        circles_set++;
    endtask

    task automatic random_pixel();
        int     span;
        t_coord px;
        t_coord py;
        t_color dest;
        span = int'(circ_r) + 2;
        if ($urandom_range(3) != 0) begin
            px = t_coord'(int'(circ_cx) + int'($urandom_range(2 * span)) - span);
            py = t_coord'(int'(circ_cy) + int'($urandom_range(2 * span)) - span);
        end else begin
            px = t_coord'($urandom_range(2047));
            py = t_coord'($urandom_range(2047));
        end
        dest = $urandom();
        send_pixel(px, py, dest, shade_pixel(px, py, dest));
    endtask

    initial begin
        // after reset: zero radius, everything passes through
        row_known(0, 0, 32'h0000_0000, 1'b1, 32'h0000_0000, 0);
        row_known(2047, 2047, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0);
        // small circle at (5,5); upper register bits must be ignored
        row_write(REG_CENTER_X, 32'hFFFF_F005);
        row_write(REG_CENTER_Y, 32'h0000_0005);
        row_write(REG_RADIUS, 32'hFFFF_F803);
        row_write(REG_FILL, 32'hFF00_00FF);
        row_known(5, 5, 32'h8011_2233, 1'b1, 32'h8000_00FF, 4);
        row_known(100, 100, 32'h8011_2233, 1'b1, 32'h8011_2233, 0);
        row_pixel(8, 5, 32'h8011_2233);
        row_pixel(2, 5, 32'h8011_2233);
        row_pixel(5, 8, 32'h8011_2233);
        row_pixel(5, 2, 32'h8011_2233);
        row_pixel(7, 7, 32'h00FF_FFFF);
        // half alpha, partial coverage on the edge
        row_write(REG_FILL, 32'h80FF_FFFF);
        row_pixel(5, 5, 32'h0000_0000);
        row_pixel(8, 5, 32'hFF00_0000);
        // most negative centre, largest radius
        row_write(REG_CENTER_X, 32'h0000_0800);
        row_write(REG_CENTER_Y, 32'h0000_0800);
        row_write(REG_RADIUS, 32'h0000_07FF);
        row_write(REG_FILL, 32'hFFFF_FFFF);
        row_pixel(0, 0, 32'h1234_5678);
        row_pixel(2047, 0, 32'h8765_4321);
        // most positive centre
        row_write(REG_CENTER_X, 32'h0000_07FF);
        row_write(REG_CENTER_Y, 32'h0000_07FF);
        row_known(2047, 2047, 32'h1234_5678, 1'b1, 32'h12FF_FFFF, 4);
        row_pixel(0, 0, 32'h1234_5678);
        row_pixel(1000, 2047, 32'h55AA_55AA);
        // zero radius right on the centre
        row_write(REG_RADIUS, 32'h0000_0000);
        row_known(2047, 2047, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 0);
        // full coverage but transparent fill
        row_write(REG_RADIUS, 32'h0000_000A);
        row_write(REG_FILL, 32'h00FF_FFFF);
        row_known(2047, 2047, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, 4);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_gap_pct = 22;
                    recv_stall_pct = 57;
                end
                1: begin
                    send_gap_pct = 57;
                    recv_stall_pct = 22;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (mode == 0) begin
                foreach (directed_rows[i]) begin
                    if (directed_rows[i].kind == ROW_WRITE) begin
                        settle_pipeline();
                        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
                    end else if (directed_rows[i].known) begin
                        send_pixel(directed_rows[i].px, directed_rows[i].py,
                                   directed_rows[i].dest, directed_rows[i].known_shade);
                    end else begin
                        send_pixel(directed_rows[i].px, directed_rows[i].py,
                                   directed_rows[i].dest,
                                   shade_pixel(directed_rows[i].px, directed_rows[i].py,
                                               directed_rows[i].dest));
                    end
                end
            end
            for (int k = 0; k < CIRCLES; k++) begin
                program_circle(mode, k);
                repeat (PIXELS_EACH) random_pixel();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_pixels.size()));
        end

        $display("Shaded %0d pixels (%0d checked) over %0d random circles, %0d cycles",
                 pixels_sent, pixels_checked, circles_set, cycle_count);
        $display("Coverage 0..4 seen: %0d %0d %0d %0d %0d, failures: %0d",
                 cov_seen[0], cov_seen[1], cov_seen[2], cov_seen[3], cov_seen[4], errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
